// ===== rtl/core/pss_pkg.sv =====
package pss_pkg;

  // default sizing
  localparam int CAPACITY_DEF   = 64;
  localparam int VALUE_BITS_DEF = 32;

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_GET    = 2'd1;
  localparam logic [1:0] CMD_SET    = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  // status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // read value for anything but a good get
  localparam logic signed [31:0] READ_NONE = -32'sd1;

  // one result item
  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [6:0]         entry_count;
  } res_t;

endpackage

// ===== rtl/core/positional_sequence_store.sv =====
// from accept to out_valid, set, clear, rejects and insert into an empty list pass through
// check and done; get through check, read wait and done; other inserts through check, a read
// and a move per entry moved back, (count - position + 1), then place and done
// each move is one registered read and one write of the entry memory; one item at a time:
// in_stall is high from accept until the result is loaded, so no new item is taken in between
// reset clears the entry count and control; entry memory is not cleared
module positional_sequence_store import pss_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic signed [31:0] item_value,
  input  logic [7:0]         position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] read_value,
  output logic [1:0]         status,
  output logic [6:0]         entry_count
);

  logic                  busy;
  logic                  done;
  logic                  start;
  logic                  out_free;
  res_t                  res;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [VALUE_BITS-1:0] mem_wdata;
  logic                  mem_re;
  logic [ADDR_W-1:0]     mem_raddr;
  logic [VALUE_BITS-1:0] mem_rdata;

  assign in_stall = busy;
  assign start    = in_valid && !busy;
  assign out_free = !out_valid || !out_stall;

  pss_seq #(
    .CAPACITY  (CAPACITY),
    .VALUE_BITS(VALUE_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .item_value(item_value),
    .position  (position),
    .out_free  (out_free),
    .busy      (busy),
    .done      (done),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  pss_mem #(
    .CAPACITY  (CAPACITY),
    .VALUE_BITS(VALUE_BITS)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      read_value  <= res.read_value;
      status      <= res.status;
      entry_count <= res.entry_count;
    end
  end

  // an accepted item keeps the input side stalled
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accept");

  // a result is only handed over when the output register is free
  a_done_when_free: assert property (@(posedge clk) disable iff (rst)
    done |-> (!out_valid || !out_stall))
    else $error("result would overwrite a waiting item");

  // failed commands never carry a read value
  a_fail_no_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_DONE) |-> (read_value == READ_NONE))
    else $error("rejected command carries a value");

  // a new result only appears out of a busy sequencer
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result without work in flight");

endmodule

// ===== rtl/core/pss_mem.sv =====
module pss_mem import pss_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [ADDR_W-1:0]     waddr,
  input  logic [VALUE_BITS-1:0] wdata,
  input  logic                  re,
  input  logic [ADDR_W-1:0]     raddr,
  output logic [VALUE_BITS-1:0] rdata
);

  logic [VALUE_BITS-1:0] mem [CAPACITY];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/pss_seq.sv =====
module pss_seq import pss_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CNT_W     = $clog2(CAPACITY + 1),
  localparam int CMP_W     = ((CNT_W > 8) ? CNT_W : 8) + 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [1:0]                   cmd,
  input  logic signed [31:0]           item_value,
  input  logic [7:0]                   position,
  input  logic                         out_free,
  output logic                         busy,
  output logic                         done,
  output res_t                         res,
  output logic                         mem_we,
  output logic [ADDR_W-1:0]            mem_waddr,
  output logic [VALUE_BITS-1:0]        mem_wdata,
  output logic                         mem_re,
  output logic [ADDR_W-1:0]            mem_raddr,
  input  logic [VALUE_BITS-1:0]        mem_rdata
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_MOVE   = 3'd3;
  localparam logic [2:0] S_PLACE  = 3'd4;
  localparam logic [2:0] S_RDWAIT = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]            state;
  logic [1:0]            cmd_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [7:0]            pos_r;
  logic [CNT_W-1:0]      count;
  logic [ADDR_W-1:0]     idx;
  logic [ADDR_W-1:0]     tgt;
  logic signed [31:0]    res_value;
  logic [1:0]            res_status;

  logic signed [63:0]    val_ext;
  logic signed [63:0]    rd_ext;
  logic [CMP_W-1:0]      pos_w;
  logic [CMP_W-1:0]      cnt_w;
  logic [CMP_W-1:0]      pos_m1;
  logic [CMP_W-1:0]      cnt_p1;
  logic [ADDR_W-1:0]     idx_m1;
  logic                  in_range;
  logic                  ins_range;
  logic                  is_full;

  // value conversion to and from the stored width
  assign val_ext = 64'(item_value);
  assign rd_ext  = 64'(signed'(mem_rdata));

  // shared compare and decrement unit
  assign pos_w     = CMP_W'(pos_r);
  assign cnt_w     = CMP_W'(count);
  assign pos_m1    = pos_w - CMP_W'(1);
  assign cnt_p1    = cnt_w + CMP_W'(1);
  assign idx_m1    = idx - ADDR_W'(1);
  assign in_range  = (pos_w != '0) && (pos_w <= cnt_w);
  assign ins_range = (pos_w != '0) && (pos_w <= cnt_p1);
  assign is_full   = (cnt_w >= CMP_W'(CAPACITY));

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE) && out_free;

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos_m1[ADDR_W-1:0];
    mem_wdata = val_r;
    mem_re    = 1'b0;
    mem_raddr = pos_m1[ADDR_W-1:0];
    case (state)
      S_CHECK: begin
        if (cmd_r == CMD_INSERT && !is_full && count == '0) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
        end else if (cmd_r == CMD_SET && in_range) begin
          mem_we = 1'b1;
        end else if (cmd_r == CMD_GET && in_range) begin
          mem_re = 1'b1;
        end
      end
      S_READ: begin
        mem_re    = 1'b1;
        mem_raddr = idx_m1;
      end
      S_MOVE: begin
        mem_we    = 1'b1;
        mem_waddr = idx;
        mem_wdata = mem_rdata;
      end
      S_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = tgt;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_r <= cmd;
            val_r <= val_ext[VALUE_BITS-1:0];
            pos_r <= position;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_value  <= READ_NONE;
          res_status <= ST_DONE;
          state      <= S_DONE;
          case (cmd_r)
            CMD_INSERT: begin
              if (is_full) begin
                res_status <= ST_FULL;
              end else if (count == '0) begin
                count <= CNT_W'(1);
              end else if (!ins_range) begin
                res_status <= ST_RANGE;
              end else begin
                idx <= count[ADDR_W-1:0];
                tgt <= pos_m1[ADDR_W-1:0];
                if (count[ADDR_W-1:0] == pos_m1[ADDR_W-1:0]) begin
                  state <= S_PLACE;
                end else begin
                  state <= S_READ;
                end
              end
            end
            CMD_GET: begin
              if (in_range) begin
                state <= S_RDWAIT;
              end else begin
                res_status <= ST_RANGE;
              end
            end
            CMD_SET: begin
              if (!in_range) begin
                res_status <= ST_RANGE;
              end
            end
            default: begin
              count <= '0;
            end
          endcase
        end
        S_READ: begin
          state <= S_MOVE;
        end
        S_MOVE: begin
          idx <= idx_m1;
          if (idx_m1 == tgt) begin
            state <= S_PLACE;
          end else begin
            state <= S_READ;
          end
        end
        S_PLACE: begin
          count <= count + CNT_W'(1);
          state <= S_DONE;
        end
        S_RDWAIT: begin
          res_value <= rd_ext[31:0];
          state     <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result item, with the count after the command
  assign res = {res_value, res_status, cnt_w[6:0]};

endmodule
